@@ rtl/modular_exponentiation_defines.svh @@
// assertion macros for the modular exponentiation block
// the macros refer to clk and rst_n in the scope where they are used
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define MEXP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define MEXP_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MEXP_ASSERT(label, prop, msg)
`define MEXP_ASSERT_NORST(label, prop, msg)
`endif

`endif

@@ rtl/mexp_pkg.sv @@
// shared types and constants for the modular exponentiation block
// no dependencies
`default_nettype none

package mexp_pkg;

  // width of the data fields on the channels (base, exponent, modulus, result)
  localparam int FIELD_W = 32;

  // status of the serial modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mexp_mul_stat_t;

endpackage

`default_nettype wire

@@ rtl/mexp_if.sv @@
// channel interfaces of the modular exponentiation block
// depends on mexp_pkg
`default_nettype none

interface mexp_in_if import mexp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] base;
  logic [FIELD_W-1:0] exponent;
  logic [FIELD_W-1:0] modulus;

  modport source (output valid, output base, output exponent, output modulus, input ready);
  modport sink (input valid, input base, input exponent, input modulus, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] result;
  logic               error;

  modport source (output valid, output result, output error, input ready);
  modport sink (input valid, input result, input error, output ready);
endinterface

`default_nettype wire

@@ rtl/modular_exponentiation.sv @@
// modular exponentiation (square and multiply) top level
// depends on mexp_pkg, mexp_if, mexp_modmul and modular_exponentiation_defines.svh
//
// usage:
//  - in_ch carries one word of base, exponent and modulus; it is taken when
//    valid and ready are both high, and ready is high only while the sequencer
//    is idle, so one word is worked on at a time
//  - out_ch carries one word of result and error per input word; it sits in an
//    output register, so a new input word is taken while a result still waits
//  - a zero modulus gives error 1 and result 0; a zero exponent gives result 1
//    with no reduction; both go from the load state straight to the done state
//  - otherwise the base is first reduced mod m, then the exponent is scanned
//    from its top bit down: square every bit, multiply on each one bit
//  - every modular multiply runs on one shared bit-serial unit
//  - a stalled receiver holds the finished result in the sequencer until the
//    output register frees up; nothing is lost or repeated
//  - reset (synchronous, active low) empties the output register and returns
//    the sequencer to idle; an item in flight is dropped
`default_nettype none
`include "modular_exponentiation_defines.svh"

module modular_exponentiation import mexp_pkg::*; #(
  parameter int WIDTH = 32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  mexp_in_if.sink   in_ch,
  mexp_out_if.source out_ch
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CNT_W-1:0] BIT_LAST = CNT_W'(WIDTH - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_RED  = 3'd2;
  localparam logic [2:0] ST_SQ   = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [WIDTH-1:0]   base_r, base_nxt;   // raw base, then base mod m
  logic [WIDTH-1:0]   exp_r, exp_nxt;     // exponent, shifted left a bit per step
  logic [WIDTH-1:0]   mod_r, mod_nxt;
  logic [WIDTH-1:0]   acc_r, acc_nxt;     // running power
  logic               err_r, err_nxt;
  logic [CNT_W-1:0]   bitcnt_r, bitcnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_result_r, out_result_nxt;
  logic               out_error_r, out_error_nxt;

  logic               mul_start;
  logic [WIDTH-1:0]   mul_x;
  logic [WIDTH-1:0]   mul_y;
  logic [WIDTH-1:0]   mul_res;
  mexp_mul_stat_t     mul_stat;
  logic [WIDTH-1:0]   one_m;              // 1 mod m

  assign one_m = (mod_r == WIDTH'(1)) ? '0 : WIDTH'(1);

  mexp_modmul #(
    .WIDTH (WIDTH)
  ) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .m     (mod_r),
    .stat  (mul_stat),
    .res   (mul_res)
  );

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    base_nxt       = base_r;
    exp_nxt        = exp_r;
    mod_nxt        = mod_r;
    acc_nxt        = acc_r;
    err_nxt        = err_r;
    bitcnt_nxt     = bitcnt_r;
    out_valid_nxt  = out_valid_r;
    out_result_nxt = out_result_r;
    out_error_nxt  = out_error_r;
    mul_start      = 1'b0;
    mul_x          = mul_res;
    mul_y          = mul_res;

    // receiver took the waiting word
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          // operands cut to WIDTH bits
          base_nxt  = in_ch.base[WIDTH-1:0];
          exp_nxt   = in_ch.exponent[WIDTH-1:0];
          mod_nxt   = in_ch.modulus[WIDTH-1:0];
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        bitcnt_nxt = '0;
        if (mod_r == '0) begin
          // zero modulus wins over zero exponent
          err_nxt   = 1'b1;
          acc_nxt   = '0;
          state_nxt = ST_DONE;
        end else if (exp_r == '0) begin
          // plain 1, not reduced even for modulus one
          err_nxt   = 1'b0;
          acc_nxt   = WIDTH'(1);
          state_nxt = ST_DONE;
        end else begin
          // reduce the base: base * (1 mod m) mod m
          err_nxt   = 1'b0;
          acc_nxt   = one_m;
          mul_start = 1'b1;
          mul_x     = base_r;
          mul_y     = one_m;
          state_nxt = ST_RED;
        end
      end
      ST_RED: begin
        if (mul_stat.done) begin
          base_nxt  = mul_res;
          mul_start = 1'b1;
          mul_x     = acc_r;
          mul_y     = acc_r;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        if (mul_stat.done) begin
          acc_nxt = mul_res;
          if (exp_r[WIDTH-1]) begin
            // one bit: multiply the square by the base
            mul_start = 1'b1;
            mul_x     = mul_res;
            mul_y     = base_r;
            state_nxt = ST_MUL;
          end else begin
            exp_nxt    = {exp_r[WIDTH-2:0], 1'b0};
            bitcnt_nxt = bitcnt_r + 1'b1;
            if (bitcnt_r == BIT_LAST) begin
              state_nxt = ST_DONE;
            end else begin
              mul_start = 1'b1;
              state_nxt = ST_SQ;
            end
          end
        end
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          acc_nxt    = mul_res;
          exp_nxt    = {exp_r[WIDTH-2:0], 1'b0};
          bitcnt_nxt = bitcnt_r + 1'b1;
          if (bitcnt_r == BIT_LAST) begin
            state_nxt = ST_DONE;
          end else begin
            // square the new product for the next bit
            mul_start = 1'b1;
            state_nxt = ST_SQ;
          end
        end
      end
      ST_DONE: begin
        // hand over once the output register is free or being emptied
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = FIELD_W'(acc_r);
          out_error_nxt  = err_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bitcnt_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bitcnt_r    <= bitcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r       <= base_nxt;
    exp_r        <= exp_nxt;
    mod_r        <= mod_nxt;
    acc_r        <= acc_nxt;
    err_r        <= err_nxt;
    out_result_r <= out_result_nxt;
    out_error_r  <= out_error_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = out_result_r;
  assign out_ch.error  = out_error_r;

  // checks
  `MEXP_ASSERT(a_accept_to_load, in_ch.valid && in_ch.ready |=> state_r == ST_LOAD, "accepted word did not start the sequencer")
  `MEXP_ASSERT(a_done_while_mul, mul_stat.done |-> (state_r == ST_RED || state_r == ST_SQ || state_r == ST_MUL), "multiplier finished outside a multiply state")
  `MEXP_ASSERT(a_no_start_busy, mul_start |-> !mul_stat.busy, "multiplier restarted while busy")
  `MEXP_ASSERT(a_error_zero, out_ch.valid && out_ch.error |-> out_ch.result == '0, "error word with nonzero result")
  `MEXP_ASSERT_NORST(a_reset_empty, !rst_n |=> !out_ch.valid, "output valid after reset")

endmodule

`default_nettype wire

@@ rtl/mexp_modmul.sv @@
// bit-serial interleaved modular multiplier: x * y mod m, one bit of x per cycle
// depends on mexp_pkg; needs y < m and m nonzero, x may be any value
`default_nettype none

module mexp_modmul import mexp_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] x,
  input  wire logic [WIDTH-1:0] y,
  input  wire logic [WIDTH-1:0] m,
  output mexp_mul_stat_t        stat,
  output logic      [WIDTH-1:0] res
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [WIDTH-1:0] acc_r, acc_nxt;
  logic [WIDTH-1:0] x_r, x_nxt;
  logic [WIDTH-1:0] y_r, y_nxt;
  logic [WIDTH-1:0] m_r, m_nxt;

  logic [WIDTH:0] m_ext;
  logic [WIDTH:0] dbl;
  logic [WIDTH:0] t1;
  logic [WIDTH:0] t2;
  logic [WIDTH:0] t3;

  // one step: acc = (2*acc + bit*y) mod m, each half kept below m by one subtract
  always_comb begin
    m_ext = {1'b0, m_r};
    dbl   = {acc_r, 1'b0};
    t1    = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
    t2    = t1 + (x_r[WIDTH-1] ? {1'b0, y_r} : '0);
    t3    = (t2 >= m_ext) ? (t2 - m_ext) : t2;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    m_nxt    = m_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      x_nxt    = x;
      y_nxt    = y;
      m_nxt    = m;
    end else if (busy_r) begin
      acc_nxt = t3[WIDTH-1:0];
      x_nxt   = {x_r[WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    m_r   <= m_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res       = acc_r;

endmodule

`default_nettype wire
